### rtl/mck_pkg.sv
// ----------------------------------------------------------------------------
// mck_pkg: shared types, constants and the Morse pattern table
// Holds the register indexes, the controller/datapath interface structs and
// the Morse element patterns for the coded part of the ASCII range.
// ----------------------------------------------------------------------------
`default_nettype none

package mck_pkg;

	localparam int CharW   = 8;
	localparam int UnitsW  = 4;
	localparam int DashW   = 3;
	localparam int MaxEl   = 7;
	localparam int ElCntW  = 3;
	localparam int CfgIdxW = 2;

	localparam logic [CharW-1:0] FoldAbove  = 8'd96;
	localparam logic [CharW-1:0] FoldBy     = 8'd32;
	localparam logic [CharW-1:0] FirstCoded = 8'd32;
	localparam logic [CharW-1:0] LastCoded  = 8'd95;

	localparam logic [CfgIdxW-1:0] CFG_DASH     = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_CHAR_GAP = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_WORD_GAP = 2'd2;

	localparam logic [DashW-1:0]  DashReset    = 3'd3;
	localparam logic [UnitsW-1:0] CharGapReset = 4'd3;
	localparam logic [UnitsW-1:0] WordGapReset = 4'd4;

	// Element count and dah flags; element 0 sits at the left (bit 6).
	typedef struct packed {
		logic [ElCntW-1:0] len;
		logic [MaxEl-1:0]  dah;
	} pattern_t;

	typedef struct packed {
		logic load;
		logic emit_on;
		logic emit_off;
		logic emit_space;
	} mck_cmd_t;

	typedef struct packed {
		logic is_space;
		logic is_coded;
		logic slot_free;
		logic el_final;
	} mck_sts_t;

	function automatic pattern_t pattern_lookup(input logic [5:0] idx);
		pattern_t p;
		p = '{len: 3'd0, dah: 7'b0000000};
		case (idx)
			6'd1:  p = '{3'd6, 7'b1010110}; // !
			6'd2:  p = '{3'd6, 7'b0100100}; // "
			6'd4:  p = '{3'd7, 7'b0001001}; // $
			6'd6:  p = '{3'd5, 7'b0100000}; // &
			6'd7:  p = '{3'd6, 7'b0111100}; // '
			6'd8:  p = '{3'd5, 7'b1011000}; // (
			6'd9:  p = '{3'd6, 7'b1011010}; // )
			6'd11: p = '{3'd5, 7'b0101000}; // +
			6'd12: p = '{3'd6, 7'b1100110}; // ,
			6'd13: p = '{3'd6, 7'b1000010}; // -
			6'd14: p = '{3'd6, 7'b0101010}; // .
			6'd15: p = '{3'd5, 7'b1001000}; // /
			6'd16: p = '{3'd5, 7'b1111100}; // 0
			6'd17: p = '{3'd5, 7'b0111100};
			6'd18: p = '{3'd5, 7'b0011100};
			6'd19: p = '{3'd5, 7'b0001100};
			6'd20: p = '{3'd5, 7'b0000100};
			6'd21: p = '{3'd5, 7'b0000000};
			6'd22: p = '{3'd5, 7'b1000000};
			6'd23: p = '{3'd5, 7'b1100000};
			6'd24: p = '{3'd5, 7'b1110000};
			6'd25: p = '{3'd5, 7'b1111000}; // 9
			6'd33: p = '{3'd2, 7'b0100000}; // A
			6'd34: p = '{3'd4, 7'b1000000};
			6'd35: p = '{3'd4, 7'b1010000};
			6'd36: p = '{3'd3, 7'b1000000};
			6'd37: p = '{3'd1, 7'b0000000};
			6'd38: p = '{3'd4, 7'b0010000};
			6'd39: p = '{3'd3, 7'b1100000};
			6'd40: p = '{3'd4, 7'b0000000};
			6'd41: p = '{3'd2, 7'b0000000};
			6'd42: p = '{3'd4, 7'b0111000};
			6'd43: p = '{3'd3, 7'b1010000};
			6'd44: p = '{3'd4, 7'b0100000};
			6'd45: p = '{3'd2, 7'b1100000};
			6'd46: p = '{3'd2, 7'b1000000};
			6'd47: p = '{3'd3, 7'b1110000};
			6'd48: p = '{3'd4, 7'b0110000};
			6'd49: p = '{3'd4, 7'b1101000};
			6'd50: p = '{3'd3, 7'b0100000};
			6'd51: p = '{3'd3, 7'b0000000};
			6'd52: p = '{3'd1, 7'b1000000};
			6'd53: p = '{3'd3, 7'b0010000};
			6'd54: p = '{3'd4, 7'b0001000};
			6'd55: p = '{3'd3, 7'b0110000};
			6'd56: p = '{3'd4, 7'b1001000};
			6'd57: p = '{3'd4, 7'b1011000};
			6'd58: p = '{3'd4, 7'b1100000}; // Z
			default: p = '{len: 3'd0, dah: 7'b0000000};
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

### rtl/mck_ctrl.sv
// ----------------------------------------------------------------------------
// mck_ctrl: keyer sequencing controller
// Walks each character through its key-on and gap segments and tells the
// datapath when to load a character and when to emit each segment.
// ----------------------------------------------------------------------------
`default_nettype none

module mck_ctrl
	import mck_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire mck_sts_t sts,
	output mck_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SPACE = 4'b0010,
		ST_ON    = 4'b0100,
		ST_OFF   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.is_space) begin
						state_d = ST_SPACE;
					end else if (sts.is_coded) begin
						state_d = ST_ON;
					end
				end
			end
			ST_SPACE: begin
				if (sts.slot_free) begin
					cmd.emit_space = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_ON: begin
				if (sts.slot_free) begin
					cmd.emit_on = 1'b1;
					state_d     = ST_OFF;
				end
			end
			ST_OFF: begin
				if (sts.slot_free) begin
					cmd.emit_off = 1'b1;
					state_d      = sts.el_final ? ST_IDLE : ST_ON;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### rtl/mck_dp.sv
// ----------------------------------------------------------------------------
// mck_dp: keyer datapath
// Holds the timing registers, decodes the character into its element pattern,
// steps through the elements and drives the registered output segment.
// ----------------------------------------------------------------------------
`default_nettype none

module mck_dp
	import mck_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [CharW-1:0]   char_code,
	input  wire logic               cfg_valid,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [UnitsW-1:0]  cfg_data,
	input  wire mck_cmd_t           cmd,
	output mck_sts_t                sts,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    key_on,
	output logic [UnitsW-1:0]       units,
	output logic                    last
);

	logic [DashW-1:0]  dash_units_q;
	logic [UnitsW-1:0] char_gap_q;
	logic [UnitsW-1:0] word_gap_q;

	logic [CharW-1:0]  folded;
	logic [5:0]        rel;
	logic              in_range;
	pattern_t          pat;

	logic [MaxEl-1:0]  dah_q;
	logic [ElCntW-1:0] rem_q;
	logic              out_valid_q;
	logic              emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_units_q <= DashReset;
			char_gap_q   <= CharGapReset;
			word_gap_q   <= WordGapReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DASH:     dash_units_q <= cfg_data[DashW-1:0];
				CFG_CHAR_GAP: char_gap_q   <= cfg_data;
				CFG_WORD_GAP: word_gap_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Lower case folds onto upper case before the table lookup.
	assign folded   = (char_code > FoldAbove) ? (char_code - FoldBy) : char_code;
	assign rel      = folded[5:0] - FirstCoded[5:0];
	assign in_range = (folded >= FirstCoded) && (folded <= LastCoded);
	assign pat      = pattern_lookup(rel);

	assign emit = cmd.emit_on | cmd.emit_off | cmd.emit_space;

	assign sts.is_space  = (folded == FirstCoded);
	assign sts.is_coded  = in_range && (pat.len != '0);
	assign sts.slot_free = ~out_valid_q | out_ready;
	assign sts.el_final  = (rem_q == '0);

	// The element under work always sits in the top bit of the dah flags.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dah_q <= pat.dah;
			rem_q <= pat.len - 3'd1;
		end else if (cmd.emit_off) begin
			dah_q <= {dah_q[MaxEl-2:0], 1'b0};
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit | (out_valid_q & ~out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_on) begin
			key_on <= 1'b1;
			units  <= dah_q[MaxEl-1] ? {1'b0, dash_units_q} : 4'd1;
			last   <= 1'b0;
		end else if (cmd.emit_off) begin
			key_on <= 1'b0;
			units  <= sts.el_final ? char_gap_q : 4'd1;
			last   <= sts.el_final;
		end else if (cmd.emit_space) begin
			key_on <= 1'b0;
			units  <= word_gap_q;
			last   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/morse_character_keyer.sv
// ----------------------------------------------------------------------------
// morse_character_keyer: ASCII to Morse keying segment encoder
// Converts one character word into its run of key-on and key-off segments.
// ----------------------------------------------------------------------------
// Each accepted character word produces 0 to 14 segment words on the output:
// one key-on segment per dit or dah, each followed by a key-off gap of one
// unit, with the final gap stretched to the character gap and flagged last.
// A space gives a single word-gap segment; characters without a code give
// nothing. Lower case is folded to upper case. The controller sends one
// segment per cycle into the output register while the output is not
// stalled; the next character is taken in the cycle after its last segment
// is loaded. The configuration port is always ready and should be written
// only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_character_keyer
	import mck_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [CharW-1:0]   char_code,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    key_on,
	output logic [UnitsW-1:0]       units,
	output logic                    last,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [UnitsW-1:0]  cfg_data
);

	mck_cmd_t cmd;
	mck_sts_t sts;

	assign cfg_ready = 1'b1;

	mck_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mck_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_code),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_on    (key_on),
		.units     (units),
		.last      (last)
	);

	// A key-on segment never ends a character.
	a_on_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_on |-> !last)
		else $error("key-on segment flagged as last");

	// Once a key-on segment is taken, its gap is ready in the next cycle.
	a_gap_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && key_on |=> out_valid && !key_on)
		else $error("gap did not follow a key-on segment");

	// Gaps inside a character are always one unit long.
	a_inner_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_on && !last |-> units == 4'd1)
		else $error("inner gap is not one unit");

	// No new character is taken while a segment is still being loaded.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.emit_on || cmd.emit_off || cmd.emit_space))
		else $error("character accepted during segment emission");

endmodule

`default_nettype wire

### test/morse_character_keyer_test.sv
// ----------------------------------------------------------------------------
// morse_character_keyer_test: self-checking testbench for the Morse keyer
// Sends character words through the valid/ready input, predicts each key-on
// and key-off segment from a local Morse table and the current register
// settings, and compares every segment word that leaves the block in order.
// Covers directed edge characters, register extremes and random traffic
// under three sender/receiver throttling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module morse_character_keyer_test;
	import mck_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic              key;
		logic [UnitsW-1:0] len;
		logic              fin;
	} segment_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [CharW-1:0]   char_code;
	logic               out_valid;
	logic               out_ready;
	logic               key_on;
	logic [UnitsW-1:0]  units;
	logic               last;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [UnitsW-1:0]  cfg_data;

	// Local copy of the keying registers.
	logic [DashW-1:0]  dash_len;
	logic [UnitsW-1:0] char_gap_len;
	logic [UnitsW-1:0] word_gap_len;

	segment_t expected_segments[$];

	int send_idle_pct;
	int recv_stall_pct;
	int errors;
	int cycle_count;
	int chars_sent;
	int silent_chars;
	int segments_checked;

	logic [CharW-1:0] edge_codes [0:23] = '{
		8'd0, 8'd255, " ", "$", "a", "z", 8'd96, 8'd127, 8'd31, "?", "@", "_",
		":", "E", "T", "0", "9", "S", "H", "G", "6", "!", 8'd128, 8'd225
	};

	morse_character_keyer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_on    (key_on),
		.units     (units),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic string morse_pattern(input logic [CharW-1:0] c);
		case (c)
			"!": return "-.-.--";
			"\"": return ".-..-.";
			"$": return "...-..-";
			"&": return ".-...";
			"'": return ".----.";
			"(": return "-.--.";
			")": return "-.--.-";
			"+": return ".-.-.";
			",": return "--..--";
			"-": return "-....-";
			".": return ".-.-.-";
			"/": return "-..-.";
			"0": return "-----";
			"1": return ".----";
			"2": return "..---";
			"3": return "...--";
			"4": return "....-";
			"5": return ".....";
			"6": return "-....";
			"7": return "--...";
			"8": return "---..";
			"9": return "----.";
			"A": return ".-";
			"B": return "-...";
			"C": return "-.-.";
			"D": return "-..";
			"E": return ".";
			"F": return "..-.";
			"G": return "--.";
			"H": return "....";
			"I": return "..";
			"J": return ".---";
			"K": return "-.-";
			"L": return ".-..";
			"M": return "--";
			"N": return "-.";
			"O": return "---";
			"P": return ".--.";
			"Q": return "--.-";
			"R": return ".-.";
			"S": return "...";
			"T": return "-";
			"U": return "..-";
			"V": return "...-";
			"W": return ".--";
			"X": return "-..-";
			"Y": return "-.--";
			"Z": return "--..";
			default: return "";
		endcase
	endfunction

	// Queues the segments one character word produces and returns their count.
	function automatic int predict_segments(input logic [CharW-1:0] code);
		logic [CharW-1:0] c;
		string            pat;
		segment_t         seg;
		int               n;
		c = code;
		n = 0;
		if (c > 8'd96) begin
			c = c - 8'd32;
		end
		if (c == " ") begin
			seg = '{key: 1'b0, len: word_gap_len, fin: 1'b1};
			expected_segments.push_back(seg);
			return 1;
		end
		pat = morse_pattern(c);
		for (int i = 0; i < pat.len(); i++) begin
			seg.key = 1'b1;
			seg.len = (pat[i] == "-") ? UnitsW'(dash_len) : UnitsW'(1);
			seg.fin = 1'b0;
			expected_segments.push_back(seg);
			seg.key = 1'b0;
			seg.fin = (i == pat.len() - 1);
			seg.len = seg.fin ? char_gap_len : UnitsW'(1);
			expected_segments.push_back(seg);
			n += 2;
		end
		return n;
	endfunction

	function automatic logic [CharW-1:0] pick_char();
		logic [CharW-1:0] c;
		string            pat;
		if ($urandom_range(99) < 25) begin
			return CharW'($urandom_range(255));
		end
		do begin
			c = CharW'($urandom_range(95, 32));
			pat = morse_pattern(c);
		end while (c != " " && pat.len() == 0);
		if (c >= "A" && c <= "Z" && $urandom_range(1) == 1) begin
			c = c + 8'd32;
		end
		return c;
	endfunction

	task automatic send_char(input logic [CharW-1:0] c, output int n);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		n = predict_segments(c);
		chars_sent++;
		if (n == 0) begin
			silent_chars++;
		end
	endtask

	// Leaves cfg_valid high so that back-to-back writes need no gap.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [UnitsW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			CFG_DASH:     dash_len = data[DashW-1:0];
			CFG_CHAR_GAP: char_gap_len = data;
			CFG_WORD_GAP: word_gap_len = data;
			default:      ;
		endcase
	endtask

	task automatic set_registers(input logic [UnitsW-1:0] dash, input logic [UnitsW-1:0] cgap,
			input logic [UnitsW-1:0] wgap);
		write_reg(CFG_DASH, dash);
		write_reg(CFG_CHAR_GAP, cgap);
		write_reg(CFG_WORD_GAP, wgap);
		cfg_valid <= 1'b0;
	endtask

	// An uncoded character leaves nothing to wait for, so let the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_segments.size() != 0 || !in_ready) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_edge_characters();
		int n;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (edge_codes[i]) begin
			send_char(edge_codes[i], n);
		end
		wait_idle();
	endtask

	task automatic test_register_extremes();
		int n;
		// A write to the unused index must leave the reset settings alone.
		write_reg(CFG_UNUSED, 4'hF);
		cfg_valid <= 1'b0;
		send_char("$", n);
		send_char(" ", n);
		wait_idle();
		set_registers(4'd2, 4'd1, 4'd1);
		send_char("$", n);
		send_char(" ", n);
		send_char("k", n);
		wait_idle();
		set_registers(4'd0, 4'd0, 4'd0);
		send_char("0", n);
		send_char(" ", n);
		send_char("E", n);
		wait_idle();
		// Bit 3 of the dah length is dropped, giving the top value 7.
		set_registers(4'hF, 4'hF, 4'hF);
		send_char("Q", n);
		send_char(" ", n);
		send_char("$", n);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int n_chars, input int idle_pct, input int stall_pct,
			input logic [UnitsW-1:0] dash, input logic [UnitsW-1:0] cgap,
			input logic [UnitsW-1:0] wgap);
		int n;
		int keyed;
		keyed = 0;
		set_registers(dash, cgap, wgap);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (keyed < n_chars) begin
			send_char(pick_char(), n);
			if (n > 0) begin
				keyed++;
			end
		end
		wait_idle();
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : check_segment
		segment_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_segments.size() == 0) begin
				$display("%0t: unexpected segment key_on=%0b units=%0d last=%0b",
					$time, key_on, units, last);
				errors++;
			end else begin
				want = expected_segments.pop_front();
				if (key_on !== want.key || units !== want.len || last !== want.fin) begin
					$display("%0t: segment mismatch: expected key_on=%0b units=%0d last=%0b,",
						$time, want.key, want.len, want.fin,
						" got key_on=%0b units=%0d last=%0b", key_on, units, last);
					errors++;
				end
				segments_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d segments outstanding", $time,
				expected_segments.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DASH;
		cfg_data = '0;
		dash_len = DashReset;
		char_gap_len = CharGapReset;
		word_gap_len = WordGapReset;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		errors = 0;
		cycle_count = 0;
		chars_sent = 0;
		silent_chars = 0;
		segments_checked = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_characters();
		test_register_extremes();
		test_random_traffic(60, 20, 58, UnitsW'($urandom_range(7, 2)),
			UnitsW'($urandom_range(15, 1)), UnitsW'($urandom_range(15, 1)));
		test_random_traffic(60, 58, 20, UnitsW'($urandom_range(7, 2)),
			UnitsW'($urandom_range(15, 1)), UnitsW'($urandom_range(15, 1)));
		test_random_traffic(60, 0, 0, 4'd7, 4'd15, 4'd15);

		$display("Sent %0d characters (%0d without a code) and checked %0d segments",
			chars_sent, silent_chars, segments_checked);
		$display("across edge codes, register extremes and three throttling mixes.");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d errors", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
